// ----- sv/clht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clht_pkg
// Shared constants, payload types and codes of the committed load history.
// ----------------------------------------------------------------------------
package clht_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LEAVES   = 1 << IDX_W;
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 38;
    localparam int LINE_OFF = 6;
    localparam int TAG_W    = ADDR_W - LINE_OFF;
    localparam int CNT_W    = 7;
    localparam int KEY_W    = CNT_W + 1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [TAG_W-1:0] t_tag;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [KEY_W-1:0] t_key;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_INVAL  = 2'd2
    } t_kind;

    typedef struct packed {
        logic              vld;
        logic [KIND_W-1:0] kind;
        t_tag              tag;
    } t_req;

    typedef struct packed {
        logic hit;
        t_cnt distance;
    } t_rsp;

endpackage

// ----- sv/clht_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clht_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface clht_in_if;
    logic                        valid;
    logic                        ready;
    logic [clht_pkg::KIND_W-1:0] kind;
    logic [clht_pkg::ADDR_W-1:0] line_addr;

    modport source (output valid, kind, line_addr, input ready);
    modport sink   (input valid, kind, line_addr, output ready);
endinterface

interface clht_out_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [clht_pkg::CNT_W-1:0] distance;

    modport source (output valid, hit, distance, input ready);
    modport sink   (input valid, hit, distance, output ready);
endinterface

// ----- sv/committed_load_history_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// committed_load_history_table
// Associative history of committed loads: insert, fusion lookup, invalidate.
// ----------------------------------------------------------------------------
// Flow: request register, then the result register when the output can advance.
// Throughput: one beat per cycle unless the output stalls; the slot match and the age
//   compare tree finish between the request register and the result register.
// Reset: synchronous; clears all slot valid bits and the commit counter at
//   once, no clearing pass.
module committed_load_history_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    clht_in_if.sink           i_in,
    clht_out_if.source        o_out
);

    logic                        r_in_valid;
    logic [clht_pkg::KIND_W-1:0] r_kind;
    clht_pkg::t_tag              r_tag;
    logic                        r_out_valid;
    logic                        r_hit;
    clht_pkg::t_cnt              r_distance;

    logic                        adv;
    logic                        take;
    logic                        n_in_valid;
    clht_pkg::t_req              req;
    clht_pkg::t_rsp              rsp;

    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || adv;
    assign take       = i_in.valid && i_in.ready;
    assign n_in_valid = take || (r_in_valid && !adv);

    assign req.vld  = r_in_valid && adv;
    assign req.kind = r_kind;
    assign req.tag  = r_tag;

    clht_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind <= i_in.kind;
            r_tag  <= i_in.line_addr[clht_pkg::ADDR_W-1:clht_pkg::LINE_OFF];
        end
        if (adv) begin
            r_hit      <= rsp.hit;
            r_distance <= rsp.distance;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.hit      = r_hit;
    assign o_out.distance = r_distance;

`ifndef SYNTHESIS
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid && $stable(r_hit) && $stable(r_distance))
        else $error("stalled result beat changed");
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> r_in_valid && $stable(r_tag) && $stable(r_kind))
        else $error("held request beat lost");
    a_hit_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_hit) |-> r_distance == '0)
        else $error("distance set without hit");
`endif

endmodule

// ----- sv/clht_victim.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clht_victim
// Replacement choice: compare tree over all slots, free slots first, then
// largest age, lowest slot on ties.
// ----------------------------------------------------------------------------
module clht_victim (
    input  logic [clht_pkg::ENTRIES-1:0] i_valid,
    input  clht_pkg::t_cnt               i_age [clht_pkg::ENTRIES],
    output clht_pkg::t_idx               o_victim
);

    clht_pkg::t_key node_key [1:2*clht_pkg::LEAVES-1];
    clht_pkg::t_idx node_idx [1:2*clht_pkg::LEAVES-1];

    for (genvar i = 0; i < clht_pkg::LEAVES; i++) begin : g_leaf
        if (i < clht_pkg::ENTRIES) begin : g_real
            assign node_key[clht_pkg::LEAVES+i] = i_valid[i] ? {1'b0, i_age[i]}
                                                             : {1'b1, {clht_pkg::CNT_W{1'b0}}};
        end else begin : g_pad
            assign node_key[clht_pkg::LEAVES+i] = '0;
        end
        assign node_idx[clht_pkg::LEAVES+i] = clht_pkg::IDX_W'(i);
    end

    for (genvar k = 1; k < clht_pkg::LEAVES; k++) begin : g_node
        logic take_right;
        assign take_right  = node_key[2*k+1] > node_key[2*k];
        assign node_key[k] = take_right ? node_key[2*k+1] : node_key[2*k];
        assign node_idx[k] = take_right ? node_idx[2*k+1] : node_idx[2*k];
    end

    assign o_victim = node_idx[1];

endmodule

// ----- sv/clht_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clht_table
// Slot storage, parallel tag match, commit counter and per-beat update.
// ----------------------------------------------------------------------------
module clht_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  clht_pkg::t_req i_req,
    output clht_pkg::t_rsp o_rsp
);

    logic [clht_pkg::ENTRIES-1:0] r_valid;
    clht_pkg::t_tag               r_tag    [clht_pkg::ENTRIES];
    clht_pkg::t_cnt               r_commit [clht_pkg::ENTRIES];
    clht_pkg::t_cnt               r_count;

    clht_pkg::t_cnt               age [clht_pkg::ENTRIES];
    logic [clht_pkg::ENTRIES-1:0] match;
    logic                         found;
    clht_pkg::t_idx               match_idx;
    clht_pkg::t_idx               victim;
    clht_pkg::t_cnt               n_count;
    logic                         is_insert;
    logic                         is_lookup;
    logic                         is_inval;

    always_comb begin
        for (int i = 0; i < clht_pkg::ENTRIES; i++) begin
            age[i]   = r_count - r_commit[i];
            match[i] = r_valid[i] && (r_tag[i] == i_req.tag);
        end
    end

    always_comb begin
        found     = 1'b0;
        match_idx = '0;
        for (int i = clht_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                found     = 1'b1;
                match_idx = clht_pkg::IDX_W'(i);
            end
        end
    end

    clht_victim u_victim (
        .i_valid  (r_valid),
        .i_age    (age),
        .o_victim (victim)
    );

    always_comb begin
        is_insert = 1'b0;
        is_lookup = 1'b0;
        is_inval  = 1'b0;
        unique case (i_req.kind)
            clht_pkg::KIND_INSERT: is_insert = i_req.vld;
            clht_pkg::KIND_LOOKUP: is_lookup = i_req.vld;
            clht_pkg::KIND_INVAL:  is_inval  = i_req.vld;
            default: ;
        endcase
        n_count = r_count + clht_pkg::CNT_W'(1);
    end

    assign o_rsp.hit      = is_lookup && found;
    assign o_rsp.distance = (is_lookup && found) ? (r_count - r_commit[match_idx]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            if (is_insert) begin
                r_valid[victim] <= 1'b1;
                r_count         <= n_count;
            end
            if (is_lookup) begin
                r_count <= n_count;
            end
            if ((is_lookup || is_inval) && found) begin
                r_valid[match_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_insert) begin
            r_tag[victim]    <= i_req.tag;
            r_commit[victim] <= r_count;
        end
    end

`ifndef SYNTHESIS
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_insert |=> r_count == clht_pkg::CNT_W'($past(r_count) + 1'b1))
        else $error("counter did not advance on insert");
    a_inval_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_inval |=> $stable(r_count))
        else $error("counter moved on invalidate");
    a_hit_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.hit |=> $countones(r_valid) == $countones($past(r_valid)) - 1)
        else $error("hit did not free exactly one slot");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_insert && !(&r_valid)) |=> $countones(r_valid) == $countones($past(r_valid)) + 1)
        else $error("insert into free slot did not fill one slot");
`endif

endmodule
